### rtl/thermostat_relay_with_persistence_defines.svh
// Assertion macros for the thermostat relay RTL.
`ifndef THERMOSTAT_RELAY_WITH_PERSISTENCE_DEFINES_SVH
`define THERMOSTAT_RELAY_WITH_PERSISTENCE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("thermostat relay: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("thermostat relay: next-cycle check failed");

`endif

### rtl/trp_pkg.sv
// Types and constants shared by the thermostat relay modules.
package trp_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_DAY_THRESHOLD   = 3'd0;
   localparam logic [2:0] REG_NIGHT_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_DAY_START_HOUR  = 3'd2;
   localparam logic [2:0] REG_DAY_END_HOUR    = 3'd3;
   localparam logic [2:0] REG_PERSIST_LIMIT   = 3'd4;
   localparam logic [2:0] REG_LIGHT_THRESHOLD = 3'd5;
   localparam logic [2:0] REG_MISSING_LIMIT   = 3'd6;

   localparam logic [7:0] RST_DAY_THRESHOLD   = 8'd25;
   localparam logic [7:0] RST_NIGHT_THRESHOLD = 8'd17;
   localparam logic [4:0] RST_DAY_START_HOUR  = 5'd8;
   localparam logic [4:0] RST_DAY_END_HOUR    = 5'd23;
   localparam logic [6:0] RST_PERSIST_LIMIT   = 7'd10;
   localparam logic [7:0] RST_LIGHT_THRESHOLD = 8'd30;
   localparam logic [6:0] RST_MISSING_LIMIT   = 7'd10;

   localparam logic [6:0] SAT_MAX = 7'd100;

   localparam logic MODE_SAMPLE  = 1'b0;
   localparam logic MODE_MISSING = 1'b1;

   typedef struct packed {
      logic [7:0] day_threshold;
      logic [7:0] night_threshold;
      logic [4:0] day_start_hour;
      logic [4:0] day_end_hour;
      logic [6:0] persist_limit;
      logic [7:0] light_threshold;
      logic [6:0] missing_limit;
   } cfg_type;

   typedef struct packed {
      logic       last_above;
      logic [6:0] run_count;
      logic [6:0] missing_count;
      logic       cooler_state;
      logic       light_state;
   } state_type;

   typedef struct packed {
      logic        mode;
      logic [4:0]  hour_of_day;
      logic [15:0] raw_temperature;
   } item_type;

   // Packed so that cooler_on lands in bit 0 of the result tdata.
   typedef struct packed {
      logic               shown_state;
      logic               is_day;
      logic [6:0]         fraction_hundredths;
      logic signed [12:0] whole_degrees;
      logic               light_on;
      logic               cooler_on;
   } result_type;

endpackage

### rtl/trp_eval.sv
// Combinational evaluation of one item: temperature split, day window and relay state update.
module trp_eval (
   input  trp_pkg::item_type   item,
   input  trp_pkg::cfg_type    cfg,
   input  trp_pkg::state_type  state,
   output trp_pkg::state_type  state_next,
   output trp_pkg::result_type result
);
   import trp_pkg::*;

   logic               is_day;
   logic               neg;
   logic [16:0]        mag;
   logic [12:0]        whole_mag;
   logic signed [12:0] whole;
   logic [8:0]         frac_prod;
   logic [6:0]         frac;
   logic signed [12:0] thr_day_ext;
   logic signed [12:0] thr_night_ext;
   logic signed [12:0] thr_light_ext;
   logic signed [12:0] thr;
   logic               above;
   logic               fired;
   logic [6:0]         run_next;
   logic [6:0]         miss_next;
   logic               forced;

   // Hundredths are floor(25*m/4), so the whole part is m/16 and the fraction
   // comes from the low four bits of the magnitude alone.
   always_comb begin
      is_day        = (item.hour_of_day > cfg.day_start_hour) &&
                      (item.hour_of_day < cfg.day_end_hour);
      neg           = item.raw_temperature[15];
      mag           = neg ? (17'd0 - {item.raw_temperature[15], item.raw_temperature})
                          : {1'b0, item.raw_temperature};
      whole_mag     = mag[16:4];
      whole         = neg ? $signed(13'd0 - whole_mag) : $signed(whole_mag);
      frac_prod     = {5'd0, mag[3:0]} * 9'd25;
      frac          = frac_prod[8:2];
      thr_day_ext   = $signed({{5{cfg.day_threshold[7]}}, cfg.day_threshold});
      thr_night_ext = $signed({{5{cfg.night_threshold[7]}}, cfg.night_threshold});
      thr_light_ext = $signed({{5{cfg.light_threshold[7]}}, cfg.light_threshold});
      thr           = is_day ? thr_day_ext : thr_night_ext;
      above         = whole > thr;
      if (above == state.last_above) begin
         run_next = (state.run_count >= SAT_MAX) ? SAT_MAX : state.run_count + 7'd1;
      end else begin
         run_next = 7'd0;
      end
      fired     = run_next > cfg.persist_limit;
      miss_next = (state.missing_count >= SAT_MAX) ? SAT_MAX : state.missing_count + 7'd1;
      forced    = miss_next > cfg.missing_limit;

      state_next                 = state;
      result.is_day              = is_day;
      result.whole_degrees       = 13'sd0;
      result.fraction_hundredths = 7'd0;
      result.shown_state         = 1'b0;
      unique case (item.mode)
         MODE_SAMPLE: begin
            state_next.missing_count = 7'd0;
            state_next.light_state   = is_day && (whole < thr_light_ext);
            state_next.run_count     = run_next;
            state_next.last_above    = above;
            if (fired) begin
               state_next.cooler_state = above;
            end
            result.whole_degrees       = whole;
            result.fraction_hundredths = frac;
            result.shown_state         = above ? fired : !fired;
         end
         MODE_MISSING: begin
            state_next.missing_count = miss_next;
            if (forced) begin
               state_next.cooler_state = 1'b1;
               state_next.light_state  = 1'b0;
            end
            result.shown_state = state_next.cooler_state;
         end
         default: begin
            state_next = state;
         end
      endcase
      result.cooler_on = state_next.cooler_state;
      result.light_on  = state_next.light_state;
   end

endmodule

### rtl/thermostat_relay_with_persistence.sv
// Top level of the thermostat relay: stream channels, register port, state and pipeline.
//
//   Channel   Direction  Transaction content
//   req_*     in         one sensor poll: mode in tuser, temperature and hour in tdata
//   rsp_*     out        one result per poll: relay states, split temperature, flags
//   csr_*     in/out     register writes and reads, one register per word
//
// An item goes from acceptance into the input register, then through the
// evaluation logic into the result register. One item is accepted every cycle
// while the result side keeps up; the relay state registers update in the cycle
// a result is loaded. Reset is synchronous and empties both stages.
// A stalled result holds its register and the input stage backs up behind it.
module thermostat_relay_with_persistence (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: raw_temperature[15:0], hour_of_day[20:16], zero pad.
   input  logic [trp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: mode.
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: cooler_on, light_on, whole_degrees[14:2],
   // fraction_hundredths[21:15], is_day[22], shown_state[23].
   output logic [trp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [trp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [trp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [trp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import trp_pkg::*;

   `include "thermostat_relay_with_persistence_defines.svh"

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;
   item_type   in_ff;
   item_type   in_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type out_ff;
   result_type out_in;
   result_type result;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       req_accept;
   logic       out_load;
   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DAY_THRESHOLD:   cfg_in.day_threshold   = csr_pwdata[7:0];
            REG_NIGHT_THRESHOLD: cfg_in.night_threshold = csr_pwdata[7:0];
            REG_DAY_START_HOUR:  cfg_in.day_start_hour  = csr_pwdata[4:0];
            REG_DAY_END_HOUR:    cfg_in.day_end_hour    = csr_pwdata[4:0];
            REG_PERSIST_LIMIT:   cfg_in.persist_limit   = csr_pwdata[6:0];
            REG_LIGHT_THRESHOLD: cfg_in.light_threshold = csr_pwdata[7:0];
            REG_MISSING_LIMIT:   cfg_in.missing_limit   = csr_pwdata[6:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DAY_THRESHOLD:   csr_prdata = {24'd0, cfg_ff.day_threshold};
         REG_NIGHT_THRESHOLD: csr_prdata = {24'd0, cfg_ff.night_threshold};
         REG_DAY_START_HOUR:  csr_prdata = {27'd0, cfg_ff.day_start_hour};
         REG_DAY_END_HOUR:    csr_prdata = {27'd0, cfg_ff.day_end_hour};
         REG_PERSIST_LIMIT:   csr_prdata = {25'd0, cfg_ff.persist_limit};
         REG_LIGHT_THRESHOLD: csr_prdata = {24'd0, cfg_ff.light_threshold};
         REG_MISSING_LIMIT:   csr_prdata = {25'd0, cfg_ff.missing_limit};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_in.mode            = req_tuser;
      in_in.hour_of_day     = req_tdata[20:16];
      in_in.raw_temperature = req_tdata[15:0];
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_in   = out_load ? result : out_ff;
      state_in = out_load ? state_next : state_ff;
   end

   trp_eval u_eval (
      .item       (in_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.day_threshold   <= RST_DAY_THRESHOLD;
         cfg_ff.night_threshold <= RST_NIGHT_THRESHOLD;
         cfg_ff.day_start_hour  <= RST_DAY_START_HOUR;
         cfg_ff.day_end_hour    <= RST_DAY_END_HOUR;
         cfg_ff.persist_limit   <= RST_PERSIST_LIMIT;
         cfg_ff.light_threshold <= RST_LIGHT_THRESHOLD;
         cfg_ff.missing_limit   <= RST_MISSING_LIMIT;
         state_ff.last_above    <= 1'b0;
         state_ff.run_count     <= 7'd0;
         state_ff.missing_count <= 7'd0;
         state_ff.cooler_state  <= 1'b1;
         state_ff.light_state   <= 1'b0;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= in_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   `TRP_ASSERT_SAME(a_counters_saturate, clock, reset, 1'b1,
      (state_ff.run_count <= SAT_MAX) && (state_ff.missing_count <= SAT_MAX))
   `TRP_ASSERT_SAME(a_result_matches_state, clock, reset, rsp_tvalid,
      (out_ff.cooler_on == state_ff.cooler_state) && (out_ff.light_on == state_ff.light_state))
   `TRP_ASSERT_NEXT(a_sample_clears_missing, clock, reset,
      out_load && (in_ff.mode == MODE_SAMPLE), state_ff.missing_count == 7'd0)

endmodule
